FILE: rtl/grm_pkg.sv
`default_nettype none

package grm_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DPAD_THR  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DEAD_ZONE_RST = 15'd8000;
    localparam logic [CFG_DATA_W-1:0] DPAD_THR_RST  = 15'd16000;

    // Divisor bases of the two scaling branches
    localparam logic [15:0] POS_SPAN = 16'd32767;
    localparam logic [15:0] NEG_SPAN = 16'd32768;

    // Reciprocal: floor(2^RECIP_SHIFT / d)
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int NUM_W       = 23;
    localparam int QUO_W       = 8;

    localparam int          STICKS = 4;
    localparam logic [7:0]  CENTER = 8'd128;

    // Stick lane order
    localparam int STK_LX = 0;
    localparam int STK_LY = 1;
    localparam int STK_RX = 2;
    localparam int STK_RY = 3;

    // Report button bit positions
    localparam int BTN_Y      = 0;
    localparam int BTN_B      = 1;
    localparam int BTN_A      = 2;
    localparam int BTN_X      = 3;
    localparam int BTN_L      = 4;
    localparam int BTN_R      = 5;
    localparam int BTN_ZL     = 6;
    localparam int BTN_ZR     = 7;
    localparam int BTN_BACK   = 8;
    localparam int BTN_START  = 9;
    localparam int BTN_LCLICK = 10;
    localparam int BTN_RCLICK = 11;
    localparam int BTN_GUIDE  = 12;
    localparam int BTN_SHARE  = 13;
    localparam int BTN_W      = 14;

    // Raw button positions
    localparam int RAW_B      = 0;
    localparam int RAW_A      = 1;
    localparam int RAW_Y      = 2;
    localparam int RAW_X      = 3;
    localparam int RAW_L      = 4;
    localparam int RAW_R      = 5;
    localparam int RAW_MINUS  = 6;
    localparam int RAW_PLUS   = 7;
    localparam int RAW_LSTICK = 9;
    localparam int RAW_RSTICK = 10;

    // Hat codes
    localparam logic [3:0] HAT_N    = 4'd0;
    localparam logic [3:0] HAT_NE   = 4'd1;
    localparam logic [3:0] HAT_E    = 4'd2;
    localparam logic [3:0] HAT_SE   = 4'd3;
    localparam logic [3:0] HAT_S    = 4'd4;
    localparam logic [3:0] HAT_SW   = 4'd5;
    localparam logic [3:0] HAT_W    = 4'd6;
    localparam logic [3:0] HAT_NW   = 4'd7;
    localparam logic [3:0] HAT_IDLE = 4'd8;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
        logic e;
    } t_pipe_en;

    typedef struct packed {
        logic [15:0] raw_buttons;
        logic        zl;
        logic        zr;
        logic        up;
        logic        down;
        logic        left;
        logic        right;
    } t_side;

    typedef logic [STICKS-1:0][7:0] t_stick_vec;

endpackage

`default_nettype wire

FILE: rtl/grm_in_if.sv
`default_nettype none

interface grm_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] raw_buttons;
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] left_trigger_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic signed [15:0] right_trigger_raw;
    logic signed [15:0] dpad_x_raw;
    logic signed [15:0] dpad_y_raw;

    modport source (
        output valid, raw_buttons, left_x_raw, left_y_raw, left_trigger_raw,
               right_x_raw, right_y_raw, right_trigger_raw, dpad_x_raw, dpad_y_raw,
        input  ready
    );

    modport sink (
        input  valid, raw_buttons, left_x_raw, left_y_raw, left_trigger_raw,
               right_x_raw, right_y_raw, right_trigger_raw, dpad_x_raw, dpad_y_raw,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/grm_out_if.sv
`default_nettype none

interface grm_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] report_buttons;
    logic [3:0]  hat;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;

    modport source (
        output valid, report_buttons, hat, left_x, left_y, right_x, right_y,
        input  ready
    );

    modport sink (
        input  valid, report_buttons, hat, left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/grm_recip.sv
`default_nettype none

// Restoring divider: floor(2^RECIP_SHIFT / divisor), one quotient bit a cycle.
module grm_recip
    import grm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_div,
    output logic                    o_busy,
    output logic [RECIP_W-1:0]      o_recip
);

    localparam int CNT_W = $clog2(RECIP_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0]        r_rem;
    logic [15:0]        r_div;
    logic [RECIP_W-1:0] r_quo;

    logic [16:0] n_trial;
    logic        n_fit;

    always_comb begin
        n_trial = {r_rem, (r_cnt == CNT_W'(RECIP_SHIFT))};
        n_fit   = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RECIP_SHIFT);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_div;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? 16'(n_trial - {1'b0, r_div}) : n_trial[15:0];
            r_quo <= {r_quo[RECIP_W-2:0], n_fit};
        end
    end

    assign o_busy  = r_busy;
    assign o_recip = r_quo;

endmodule

`default_nettype wire

FILE: rtl/grm_lane.sv
`default_nettype none

// One stick axis: dead zone test, scale numerator, reciprocal multiply,
// then a single remainder correction.
module grm_lane
    import grm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_pipe_en           i_en,
    input  wire logic [15:0]        i_v,
    input  wire logic [14:0]        i_dz,
    input  wire logic [15:0]        i_d_pos,
    input  wire logic [15:0]        i_d_neg,
    input  wire logic [RECIP_W-1:0] i_r_pos,
    input  wire logic [RECIP_W-1:0] i_r_neg,
    output logic [7:0]              o_s
);

    typedef struct packed {
        logic pos;
        logic ctr;
        logic zero;
    } t_lflag;

    // stage a
    logic [15:0]        r_v_a;
    // stage b
    logic [NUM_W-1:0]   r_n_b;
    t_lflag             r_f_b;
    // stage c
    logic [NUM_W-1:0]   r_n_c;
    logic [QUO_W-1:0]   r_q0_c;
    logic [15:0]        r_d_c;
    t_lflag             r_f_c;
    // stage d
    logic [NUM_W-1:0]   r_n_d;
    logic [QUO_W-1:0]   r_q0_d;
    logic [15:0]        r_d_d;
    logic [23:0]        r_prod_d;
    t_lflag             r_f_d;

    logic signed [16:0]           n_v17;
    logic signed [16:0]           n_dz17;
    logic signed [16:0]           n_diff;
    logic [15:0]                  n_mag;
    logic [NUM_W-1:0]             n_num;
    t_lflag                       n_f;
    logic [NUM_W+RECIP_W-1:0]     n_p;
    logic [NUM_W-1:0]             n_rem;
    logic [8:0]                   n_q;
    logic [8:0]                   n_s;

    always_comb begin
        n_v17  = $signed({r_v_a[15], r_v_a});
        n_dz17 = $signed({2'b00, i_dz});
        n_f.pos  = n_v17 >= n_dz17;
        n_f.ctr  = (n_v17 > -n_dz17) && (n_v17 < n_dz17);
        n_f.zero = n_f.pos && (i_d_pos == '0);
        n_diff = n_f.pos ? (n_v17 - n_dz17) : (-n_v17 - n_dz17);
        n_mag  = n_diff[15:0];
        // x127 on the positive side, x128 on the negative side
        n_num  = n_f.pos ? ({n_mag, 7'b0} - NUM_W'(n_mag)) : {n_mag, 7'b0};
    end

    always_comb begin
        n_p = (NUM_W+RECIP_W)'(r_n_b)
            * (NUM_W+RECIP_W)'(r_f_b.pos ? i_r_pos : i_r_neg);
    end

    always_comb begin
        n_rem = r_n_d - r_prod_d[NUM_W-1:0];
        n_q   = 9'(r_q0_d) + 9'(n_rem >= NUM_W'(r_d_d));
        n_s   = r_f_d.pos ? (9'(CENTER) + n_q) : (9'(CENTER) - n_q);
        o_s   = (r_f_d.ctr || r_f_d.zero) ? CENTER : n_s[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_v_a <= i_v;
        end
        if (i_en.b) begin
            r_n_b <= n_num;
            r_f_b <= n_f;
        end
        if (i_en.c) begin
            r_n_c  <= r_n_b;
            r_q0_c <= n_p[RECIP_SHIFT +: QUO_W];
            r_d_c  <= r_f_b.pos ? i_d_pos : i_d_neg;
            r_f_c  <= r_f_b;
        end
        if (i_en.d) begin
            r_n_d    <= r_n_c;
            r_q0_d   <= r_q0_c;
            r_d_d    <= r_d_c;
            r_prod_d <= 24'(r_q0_c) * 24'(r_d_c);
            r_f_d    <= r_f_c;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/grm_merge.sv
`default_nettype none

// Combine the lane results with buttons and hat into the output register.
module grm_merge
    import grm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire t_pipe_en     i_en,
    input  wire t_side        i_side,
    input  wire t_stick_vec   i_stick,
    output logic [BTN_W-1:0]  o_buttons,
    output logic [3:0]        o_hat,
    output logic [7:0]        o_lx,
    output logic [7:0]        o_ly,
    output logic [7:0]        o_rx,
    output logic [7:0]        o_ry
);

    logic [BTN_W-1:0] r_buttons;
    logic [3:0]       r_hat;
    t_stick_vec       r_stick;

    logic [BTN_W-1:0] n_buttons;
    logic [3:0]       n_hat;
    logic             n_home;
    logic             n_capture;

    always_comb begin
        n_buttons             = '0;
        n_buttons[BTN_B]      = i_side.raw_buttons[RAW_B];
        n_buttons[BTN_A]      = i_side.raw_buttons[RAW_A];
        n_buttons[BTN_Y]      = i_side.raw_buttons[RAW_Y];
        n_buttons[BTN_X]      = i_side.raw_buttons[RAW_X];
        n_buttons[BTN_L]      = i_side.raw_buttons[RAW_L];
        n_buttons[BTN_R]      = i_side.raw_buttons[RAW_R];
        n_buttons[BTN_ZL]     = i_side.zl;
        n_buttons[BTN_ZR]     = i_side.zr;
        n_home    = i_side.raw_buttons[RAW_LSTICK] && i_side.raw_buttons[RAW_RSTICK];
        n_capture = i_side.raw_buttons[RAW_MINUS] && i_side.raw_buttons[RAW_PLUS];
        n_buttons[BTN_BACK]   = i_side.raw_buttons[RAW_MINUS] && !n_capture;
        n_buttons[BTN_START]  = i_side.raw_buttons[RAW_PLUS] && !n_capture;
        n_buttons[BTN_LCLICK] = i_side.raw_buttons[RAW_LSTICK] && !n_home;
        n_buttons[BTN_RCLICK] = i_side.raw_buttons[RAW_RSTICK] && !n_home;
        n_buttons[BTN_GUIDE]  = n_home;
        n_buttons[BTN_SHARE]  = n_capture;
    end

    // diagonals first
    always_comb begin
        if (i_side.up && i_side.right) begin
            n_hat = HAT_NE;
        end else if (i_side.up && i_side.left) begin
            n_hat = HAT_NW;
        end else if (i_side.down && i_side.right) begin
            n_hat = HAT_SE;
        end else if (i_side.down && i_side.left) begin
            n_hat = HAT_SW;
        end else if (i_side.up) begin
            n_hat = HAT_N;
        end else if (i_side.down) begin
            n_hat = HAT_S;
        end else if (i_side.left) begin
            n_hat = HAT_W;
        end else if (i_side.right) begin
            n_hat = HAT_E;
        end else begin
            n_hat = HAT_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.e) begin
            r_buttons <= n_buttons;
            r_hat     <= n_hat;
            r_stick   <= i_stick;
        end
    end

    assign o_buttons = r_buttons;
    assign o_hat     = r_hat;
    assign o_lx      = r_stick[STK_LX];
    assign o_ly      = r_stick[STK_LY];
    assign o_rx      = r_stick[STK_RX];
    assign o_ry      = r_stick[STK_RY];

endmodule

`default_nettype wire

FILE: rtl/gamepad_report_mapper.sv
`default_nettype none

// Channel    Dir  Beat
// i_pad      in   16 raw buttons + 8 signed 16-bit axes (one snapshot)
// o_report   out  14 report buttons, 4-bit hat, 4 scaled sticks
// i_cfg_*    in   register write: 0 dead_zone, 1 dpad_threshold
//
// One snapshot per cycle sustained while o_report is ready and no divider
// runs; each beat passes four lane stages plus the output register.
// The stick dividers are reciprocals of the dead-zone spans, built by two
// restoring dividers: after reset and after every dead_zone write, i_pad.ready
// is held low while they run.
// A stalled o_report holds its beat; the stages behind it close up their
// bubbles and only then hold, so input keeps flowing while gaps remain.
module gamepad_report_mapper
    import grm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    grm_in_if.sink                     i_pad,
    grm_out_if.source                  o_report
);

    // Configuration
    logic [CFG_DATA_W-1:0] r_dead_zone;
    logic [CFG_DATA_W-1:0] r_dpad_thr;
    logic                  r_recalc;

    // Pipeline occupancy
    logic r_vld_a;
    logic r_vld_b;
    logic r_vld_c;
    logic r_vld_d;
    logic r_vld_e;

    // Button/hat side band travelling beside the lanes
    t_side r_side_a;
    t_side r_side_b;
    t_side r_side_c;
    t_side r_side_d;

    t_pipe_en           n_en;
    t_side              n_side;
    t_stick_vec         n_stick;
    logic               n_accept;
    logic               n_blocked;
    logic               n_pos_busy;
    logic               n_neg_busy;
    logic [15:0]        n_d_pos;
    logic [15:0]        n_d_neg;
    logic [RECIP_W-1:0] n_r_pos;
    logic [RECIP_W-1:0] n_r_neg;
    logic [15:0]        n_axis [STICKS];
    logic signed [16:0] n_thr17;

    // Move each stage on when it is empty or the next one moves
    always_comb begin
        n_en.e = !r_vld_e || o_report.ready;
        n_en.d = !r_vld_d || n_en.e;
        n_en.c = !r_vld_c || n_en.d;
        n_en.b = !r_vld_b || n_en.c;
        n_en.a = !r_vld_a || n_en.b;
    end

    assign n_blocked   = r_recalc || n_pos_busy || n_neg_busy;
    assign i_pad.ready = n_en.a && !n_blocked;
    assign n_accept    = i_pad.valid && i_pad.ready;
    assign o_report.valid = r_vld_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_ZONE_RST;
            r_dpad_thr  <= DPAD_THR_RST;
            r_recalc    <= 1'b1;
        end else begin
            r_recalc <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEAD_ZONE: begin
                        r_dead_zone <= i_cfg_data;
                        r_recalc    <= 1'b1;
                    end
                    REG_DPAD_THR: begin
                        r_dpad_thr <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            if (n_en.a) r_vld_a <= n_accept;
            if (n_en.b) r_vld_b <= r_vld_a;
            if (n_en.c) r_vld_c <= r_vld_b;
            if (n_en.d) r_vld_d <= r_vld_c;
            if (n_en.e) r_vld_e <= r_vld_d;
        end
    end

    // Triggers and d-pad directions are settled at the input
    always_comb begin
        n_thr17            = $signed({2'b00, r_dpad_thr});
        n_side.raw_buttons = i_pad.raw_buttons;
        n_side.zl          = i_pad.left_trigger_raw > 16'sd0;
        n_side.zr          = i_pad.right_trigger_raw > 16'sd0;
        n_side.up          = 17'(i_pad.dpad_y_raw) < -n_thr17;
        n_side.down        = 17'(i_pad.dpad_y_raw) > n_thr17;
        n_side.left        = 17'(i_pad.dpad_x_raw) < -n_thr17;
        n_side.right       = 17'(i_pad.dpad_x_raw) > n_thr17;
    end

    always_ff @(posedge i_clk) begin
        if (n_en.a) r_side_a <= n_side;
        if (n_en.b) r_side_b <= r_side_a;
        if (n_en.c) r_side_c <= r_side_b;
        if (n_en.d) r_side_d <= r_side_c;
    end

    // Spans of the two scaling branches
    assign n_d_pos = POS_SPAN - {1'b0, r_dead_zone};
    assign n_d_neg = NEG_SPAN - {1'b0, r_dead_zone};

    grm_recip u_recip_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_recalc),
        .i_div   (n_d_pos),
        .o_busy  (n_pos_busy),
        .o_recip (n_r_pos)
    );

    grm_recip u_recip_neg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_recalc),
        .i_div   (n_d_neg),
        .o_busy  (n_neg_busy),
        .o_recip (n_r_neg)
    );

    assign n_axis[STK_LX] = i_pad.left_x_raw;
    assign n_axis[STK_LY] = i_pad.left_y_raw;
    assign n_axis[STK_RX] = i_pad.right_x_raw;
    assign n_axis[STK_RY] = i_pad.right_y_raw;

    for (genvar g = 0; g < STICKS; g++) begin : g_lane
        grm_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_v     (n_axis[g]),
            .i_dz    (r_dead_zone),
            .i_d_pos (n_d_pos),
            .i_d_neg (n_d_neg),
            .i_r_pos (n_r_pos),
            .i_r_neg (n_r_neg),
            .o_s     (n_stick[g])
        );
    end

    grm_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_side    (r_side_d),
        .i_stick   (n_stick),
        .o_buttons (o_report.report_buttons),
        .o_hat     (o_report.hat),
        .o_lx      (o_report.left_x),
        .o_ly      (o_report.left_y),
        .o_rx      (o_report.right_x),
        .o_ry      (o_report.right_y)
    );

endmodule

`default_nettype wire

FILE: dv/gamepad_report_mapper_test.sv
`default_nettype none

// Checks gamepad_report_mapper against a behavioural copy of its mapping.
module gamepad_report_mapper_test
    import grm_pkg::*;
();

    localparam int          NUM_DIRECTED = 23;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 168;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PRESS_ITEMS  = 60;
    localparam int unsigned SETTLE       = 10;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned MAX_SHOWN    = 10;

    localparam logic signed [15:0] AX_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] AX_MIN  = 16'sh8000;
    localparam logic signed [15:0] AX_ZERO = 16'sd0;
    localparam logic        [7:0]  STK_MAX = 8'd255;
    localparam logic        [7:0]  STK_MIN = 8'd0;

    // One snapshot beat, in the order of the pad channel
    typedef struct packed {
        logic        [15:0] raw_buttons;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] left_trigger;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_trigger;
        logic signed [15:0] dpad_x;
        logic signed [15:0] dpad_y;
    } t_snapshot;

    // One report beat
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [3:0]       hat;
        logic [7:0]       left_x;
        logic [7:0]       left_y;
        logic [7:0]       right_x;
        logic [7:0]       right_y;
    } t_report;

    // A directed row: the snapshot, and the report where it is plain to see
    typedef struct packed {
        t_snapshot snap;
        logic      fixed;
        t_report   want;
    } t_dir_row;

    localparam t_report NO_REPORT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    grm_in_if  pad_ch ();
    grm_out_if report_ch ();

    // Travels alongside the pad beat: a typed-in report replaces the prediction
    logic    beat_fixed;
    t_report beat_want;

    logic [CFG_DATA_W-1:0] dead_zone_now;
    logic [CFG_DATA_W-1:0] dpad_thr_now;

    t_report     expected_reports [$];
    int unsigned report_faults = 0;
    int unsigned cycle_count   = 0;

    // Shared idling controls: calm switches idling off on both sides,
    // hold_requests asks the report side for one long hold-off.
    bit          calm          = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned press_left    = 0;

    t_dir_row directed_rows [NUM_DIRECTED] = '{
        // Nothing pressed, everything centred
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h0000, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Every raw bit: both combinations fire and clear their single presses
        '{'{16'hFFFF, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h303F, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Unused raw bits only
        '{'{16'hF900, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h0000, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Raw button 0 lands on B
        '{'{16'h0001, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h0002, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Single menu key with single stick click, no combination
        '{'{16'h0240, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        '{'{16'h0480, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        // Both stick clicks give the guide bit alone
        '{'{16'h0600, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h1000, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Both menu keys give the share bit alone
        '{'{16'h00C0, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b1, '{14'h2000, HAT_IDLE, CENTER, CENTER, CENTER, CENTER}},
        // Triggers just above and just below zero
        '{'{16'h0000, AX_ZERO, AX_ZERO, 16'sd1, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        '{'{16'h0000, AX_ZERO, AX_ZERO, -16'sd1, AX_ZERO, AX_ZERO, 16'sd1, AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        // Every axis at its top: both shoulders, south-east, full sticks
        '{'{16'h0000, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX},
          1'b1, '{14'h00C0, HAT_SE, STK_MAX, STK_MAX, STK_MAX, STK_MAX}},
        // Every axis at its bottom: north-west, empty sticks
        '{'{16'h0000, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN},
          1'b1, '{14'h0000, HAT_NW, STK_MIN, STK_MIN, STK_MIN, STK_MIN}},
        // Cardinal d-pad directions just past the threshold
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO,
            -16'sd16001},
          1'b0, NO_REPORT},
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO,
            16'sd16001},
          1'b0, NO_REPORT},
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, -16'sd16001,
            AX_ZERO},
          1'b0, NO_REPORT},
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, 16'sd16001,
            AX_ZERO},
          1'b0, NO_REPORT},
        // Exactly at the threshold counts as nothing
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, 16'sd16000,
            -16'sd16000},
          1'b0, NO_REPORT},
        // Diagonals
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, 16'sd16001,
            -16'sd16001},
          1'b0, NO_REPORT},
        '{'{16'h0000, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, -16'sd16001,
            16'sd16001},
          1'b0, NO_REPORT},
        // Sticks inside and on the dead-zone edge
        '{'{16'h0000, 16'sd7999, -16'sd7999, AX_ZERO, 16'sd8000, -16'sd8000, AX_ZERO,
            AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        // Sticks just outside the dead zone and near full travel
        '{'{16'h0000, 16'sd8001, -16'sd8001, AX_ZERO, 16'sd32766, -16'sd32767, AX_ZERO,
            AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT},
        '{'{16'hFFFF, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX},
          1'b0, NO_REPORT},
        '{'{16'h003F, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO, AX_ZERO},
          1'b0, NO_REPORT}
    };

    gamepad_report_mapper i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pad      (pad_ch),
        .o_report   (report_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Scale one stick axis to 0..255 around the centre, outside the dead zone.
    // Divisions truncate; a zero positive span (dead zone at full travel)
    // yields no offset at all.
    function automatic logic [7:0] scale_axis(input int v, input int dz);
        int span;
        int level;
        if (v > -dz && v < dz)
            return CENTER;
        if (v >= dz) begin
            span  = int'(POS_SPAN) - dz;
            level = 128 + ((span > 0) ? ((v - dz) * 127) / span : 0);
        end else begin
            span  = int'(NEG_SPAN) - dz;
            level = 128 - ((-v - dz) * 128) / span;
        end
        if (level < 0)
            level = 0;
        if (level > 255)
            level = 255;
        return level[7:0];
    endfunction

    function automatic t_report build_report(input t_snapshot s, input int dz,
                                             input int thr);
        t_report r;
        int      dx;
        int      dy;
        bit      up;
        bit      down;
        bit      left;
        bit      right;
        r = '0;
        dx = s.dpad_x;
        dy = s.dpad_y;

        // Fixed raw-to-report mapping
        r.buttons[BTN_B]      = s.raw_buttons[RAW_B];
        r.buttons[BTN_A]      = s.raw_buttons[RAW_A];
        r.buttons[BTN_Y]      = s.raw_buttons[RAW_Y];
        r.buttons[BTN_X]      = s.raw_buttons[RAW_X];
        r.buttons[BTN_L]      = s.raw_buttons[RAW_L];
        r.buttons[BTN_R]      = s.raw_buttons[RAW_R];
        r.buttons[BTN_BACK]   = s.raw_buttons[RAW_MINUS];
        r.buttons[BTN_START]  = s.raw_buttons[RAW_PLUS];
        r.buttons[BTN_LCLICK] = s.raw_buttons[RAW_LSTICK];
        r.buttons[BTN_RCLICK] = s.raw_buttons[RAW_RSTICK];
        r.buttons[BTN_ZL]     = (s.left_trigger > 0);
        r.buttons[BTN_ZR]     = (s.right_trigger > 0);

        // Combinations replace their single presses
        if (s.raw_buttons[RAW_LSTICK] && s.raw_buttons[RAW_RSTICK]) begin
            r.buttons[BTN_GUIDE]  = 1'b1;
            r.buttons[BTN_LCLICK] = 1'b0;
            r.buttons[BTN_RCLICK] = 1'b0;
        end
        if (s.raw_buttons[RAW_MINUS] && s.raw_buttons[RAW_PLUS]) begin
            r.buttons[BTN_SHARE] = 1'b1;
            r.buttons[BTN_BACK]  = 1'b0;
            r.buttons[BTN_START] = 1'b0;
        end

        // Hat: diagonals first, then vertical, then horizontal
        up    = (dy < -thr);
        down  = (dy > thr);
        left  = (dx < -thr);
        right = (dx > thr);
        if (up && right)
            r.hat = HAT_NE;
        else if (up && left)
            r.hat = HAT_NW;
        else if (down && right)
            r.hat = HAT_SE;
        else if (down && left)
            r.hat = HAT_SW;
        else if (up)
            r.hat = HAT_N;
        else if (down)
            r.hat = HAT_S;
        else if (left)
            r.hat = HAT_W;
        else if (right)
            r.hat = HAT_E;
        else
            r.hat = HAT_IDLE;

        r.left_x  = scale_axis(s.left_x, dz);
        r.left_y  = scale_axis(s.left_y, dz);
        r.right_x = scale_axis(s.right_x, dz);
        r.right_y = scale_axis(s.right_y, dz);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random content
    // ---------------------------------------------------------------------

    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favour the rails, zero and the edges of the current dead zone and
    // threshold; the rest is uniform over the whole range.
    function automatic logic signed [15:0] pick_axis(input int dz, input int thr);
        int v;
        int nudge;
        nudge = int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = nudge;
            3:       v = dz + nudge;
            4:       v = -dz + nudge;
            5:       v = thr + nudge;
            6:       v = -thr + nudge;
            default: v = int'($urandom);
        endcase
        return v[15:0];
    endfunction

    function automatic t_snapshot random_snapshot(input int dz, input int thr);
        t_snapshot s;
        // Sparse masks now and then, so single presses show up as well
        s.raw_buttons   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom);
        s.left_x        = pick_axis(dz, thr);
        s.left_y        = pick_axis(dz, thr);
        s.left_trigger  = pick_axis(dz, thr);
        s.right_x       = pick_axis(dz, thr);
        s.right_y       = pick_axis(dz, thr);
        s.right_trigger = pick_axis(dz, thr);
        s.dpad_x        = pick_axis(dz, thr);
        s.dpad_y        = pick_axis(dz, thr);
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Pad side
    // ---------------------------------------------------------------------

    // Offer one beat and hold it until the block takes it
    task automatic offer(input t_snapshot s, input logic fixed, input t_report want);
        pad_ch.valid             <= 1'b1;
        pad_ch.raw_buttons       <= s.raw_buttons;
        pad_ch.left_x_raw        <= s.left_x;
        pad_ch.left_y_raw        <= s.left_y;
        pad_ch.left_trigger_raw  <= s.left_trigger;
        pad_ch.right_x_raw       <= s.right_x;
        pad_ch.right_y_raw       <= s.right_y;
        pad_ch.right_trigger_raw <= s.right_trigger;
        pad_ch.dpad_x_raw        <= s.dpad_x;
        pad_ch.dpad_y_raw        <= s.dpad_y;
        beat_fixed               <= fixed;
        beat_want                <= want;
        do @(posedge clk); while (!pad_ch.ready);
    endtask

    // Drop valid for a random gap, unless calm or pressing the block
    task automatic pad_gap();
        int unsigned gap;
        gap = (calm || press_left != 0) ? 0 : pick_gap();
        if (press_left != 0)
            press_left--;
        if (gap != 0) begin
            pad_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected report has come back.
    // The first edge lets the monitor log the last accepted beat.
    task automatic wait_for_reports(input int unsigned settle);
        pad_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; only call while idle
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] dz,
                                  input logic [CFG_DATA_W-1:0] thr);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_DEAD_ZONE;
        cfg_data <= dz;
        @(posedge clk);
        cfg_idx  <= REG_DPAD_THR;
        cfg_data <= thr;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] phase_dz  [PHASES];
        logic [CFG_DATA_W-1:0] phase_thr [PHASES];
        t_snapshot             snap;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = REG_DEAD_ZONE;
        cfg_data                 = '0;
        pad_ch.valid             = 1'b0;
        pad_ch.raw_buttons       = '0;
        pad_ch.left_x_raw        = '0;
        pad_ch.left_y_raw        = '0;
        pad_ch.left_trigger_raw  = '0;
        pad_ch.right_x_raw       = '0;
        pad_ch.right_y_raw       = '0;
        pad_ch.right_trigger_raw = '0;
        pad_ch.dpad_x_raw        = '0;
        pad_ch.dpad_y_raw        = '0;
        beat_fixed               = 1'b0;
        beat_want                = NO_REPORT;

        // Settings per phase: reset values first, then the extremes with
        // a couple of random ones among them, and back to the reset values.
        phase_dz[0] = DEAD_ZONE_RST;    phase_thr[0] = DPAD_THR_RST;
        phase_dz[1] = 15'd0;            phase_thr[1] = 15'd0;
        phase_dz[2] = 15'd32766;        phase_thr[2] = 15'd32767;
        phase_dz[3] = 15'd1;            phase_thr[3] = 15'd32766;
        phase_dz[4] = 15'($urandom_range(0, 32766));
        phase_thr[4] = 15'($urandom_range(0, 32767));
        phase_dz[5] = 15'd32766;        phase_thr[5] = 15'd0;
        phase_dz[6] = 15'($urandom_range(0, 32766));
        phase_thr[6] = 15'($urandom_range(0, 32767));
        phase_dz[7] = DEAD_ZONE_RST;    phase_thr[7] = DPAD_THR_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // The reset values stand in phase 0; every later phase writes both
            if (p != 0)
                apply_settings(phase_dz[p], phase_thr[p]);
            calm = (p == 5);

            if (p == 0) begin
                foreach (directed_rows[i]) begin
                    offer(directed_rows[i].snap, directed_rows[i].fixed, directed_rows[i].want);
                    pad_gap();
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the report side off for a long stretch and keep
                // offering back to back, so the pipeline fills and stalls.
                if (p == 1 && n == 20) begin
                    hold_requests++;
                    press_left = PRESS_ITEMS;
                end
                snap = random_snapshot(int'(phase_dz[p]), int'(phase_thr[p]));
                offer(snap, 1'b0, NO_REPORT);
                // Pause mid-phase until the block has emptied
                if (p == 3 && n == 60)
                    wait_for_reports(0);
                else
                    pad_gap();
            end

            // Empty the pipeline before the next register write
            wait_for_reports(SETTLE);
        end

        if (report_faults == 0 && expected_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Report side
    // ---------------------------------------------------------------------

    initial begin : report_sink
        int unsigned stall_left;
        int unsigned holds_served;
        stall_left       = 0;
        holds_served     = 0;
        report_ch.ready  = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left != 0) begin
                // Hold ready low
                stall_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD;
                report_ch.ready <= 1'b0;
            end else begin
                stall_left = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
                report_ch.ready <= (stall_left == 0);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: shadow the registers, predict on each pad beat, check each
    // report beat against the oldest prediction.
    // ---------------------------------------------------------------------

    task automatic flag_report(input string what, input t_report want, input t_report got);
        if (report_faults < MAX_SHOWN)
            $display({"%s at cycle %0d: expected btn=%h hat=%0d sticks=%0d/%0d/%0d/%0d,",
                      " got btn=%h hat=%0d sticks=%0d/%0d/%0d/%0d"},
                     what, cycle_count,
                     want.buttons, want.hat, want.left_x, want.left_y,
                     want.right_x, want.right_y,
                     got.buttons, got.hat, got.left_x, got.left_y,
                     got.right_x, got.right_y);
        report_faults++;
    endtask

    always @(posedge clk) begin
        t_snapshot taken;
        t_report   got;
        t_report   want;
        if (!rst_n) begin
            dead_zone_now <= DEAD_ZONE_RST;
            dpad_thr_now  <= DPAD_THR_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_DEAD_ZONE: dead_zone_now <= cfg_data;
                    REG_DPAD_THR:  dpad_thr_now  <= cfg_data;
                    default: ;
                endcase
            end

            if (pad_ch.valid && pad_ch.ready) begin
                taken = {pad_ch.raw_buttons, pad_ch.left_x_raw, pad_ch.left_y_raw,
                         pad_ch.left_trigger_raw, pad_ch.right_x_raw, pad_ch.right_y_raw,
                         pad_ch.right_trigger_raw, pad_ch.dpad_x_raw, pad_ch.dpad_y_raw};
                if (beat_fixed)
                    expected_reports.push_back(beat_want);
                else
                    expected_reports.push_back(
                        build_report(taken, int'(dead_zone_now), int'(dpad_thr_now)));
            end

            if (report_ch.valid && report_ch.ready) begin
                got = {report_ch.report_buttons, report_ch.hat, report_ch.left_x,
                       report_ch.left_y, report_ch.right_x, report_ch.right_y};
                if (expected_reports.size() == 0) begin
                    flag_report("unexpected report", NO_REPORT, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.buttons !== want.buttons || got.hat !== want.hat ||
                        got.left_x !== want.left_x || got.left_y !== want.left_y ||
                        got.right_x !== want.right_x || got.right_y !== want.right_y)
                        flag_report("report mismatch", want, got);
                end
            end
        end
    end

    // Give up well beyond the slowest correct run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire
